// ===== hw/rtl/vifa_pkg.sv =====
// ----------------------------------------------------------------------------
// vifa_pkg
// Shared types and constants for the versatile interface adapter: operation
// codes, register offsets, interrupt flag masks and control bit positions.
// ----------------------------------------------------------------------------
package vifa_pkg;

	// operation carried by one request
	typedef enum logic [2:0] {
		OP_READ    = 3'd0,
		OP_WRITE   = 3'd1,
		OP_TICK    = 3'd2,
		OP_SET_CA1 = 3'd3,
		OP_SET_CB1 = 3'd4
	} op_t;

	// register offsets on the bus side
	typedef enum logic [3:0] {
		REG_ORB    = 4'h0,
		REG_ORA    = 4'h1,
		REG_DDRB   = 4'h2,
		REG_DDRA   = 4'h3,
		REG_T1CL   = 4'h4,
		REG_T1CH   = 4'h5,
		REG_T1LL   = 4'h6,
		REG_T1LH   = 4'h7,
		REG_T2CL   = 4'h8,
		REG_T2CH   = 4'h9,
		REG_SR     = 4'hA,
		REG_ACR    = 4'hB,
		REG_PCR    = 4'hC,
		REG_IFR    = 4'hD,
		REG_IER    = 4'hE,
		REG_ORA_NH = 4'hF
	} reg_t;

	// interrupt flag masks (bits 0..6; bit 7 is the summary)
	localparam logic [6:0] FLG_CA2 = 7'h01;
	localparam logic [6:0] FLG_CA1 = 7'h02;
	localparam logic [6:0] FLG_SR  = 7'h04;
	localparam logic [6:0] FLG_CB1 = 7'h10;
	localparam logic [6:0] FLG_T2  = 7'h20;
	localparam logic [6:0] FLG_T1  = 7'h40;

	// control bit positions
	localparam int T1_PB7_EN_BIT     = 7;
	localparam int T1_CONTINUOUS_BIT = 6;
	localparam int T2_PULSE_MODE_BIT = 5;
	localparam int PCR_CA1_RISE      = 0;
	localparam int PCR_CB1_RISE      = 4;

	localparam logic [15:0] TIMER_MAX = 16'hFFFF;

endpackage

// ===== hw/rtl/versatile_interface_adapter_unit.sv =====
// ----------------------------------------------------------------------------
// versatile_interface_adapter_unit
// Two-port interface adapter with two 16-bit down timers, CA1/CB1 edge
// detection and a flag/enable interrupt scheme, driven one operation at a time.
// ----------------------------------------------------------------------------
// Usage:
//   A request on req_valid/req_ready carries one operation: bus read, bus
//   write, timer tick, or a new CA1 / CB1 level, plus the current port pins.
//   Every request yields exactly one response on rsp_valid/rsp_ready with the
//   read byte (zero unless a read), the IRQ level and the PB7 level after the
//   operation.
//   The request lands in the input register; when the response register is
//   free, the register file updates and the response register loads together.
//   Throughput is one request per cycle while the receiver keeps up; the limit
//   is the register file read-modify-write between the two register stages.
//   When the receiver stalls, the response register holds and the input
//   register takes one more request; req_ready drops only when both are full.
//   Reset clears ports, directions, control, flags and enables, sets both
//   timer counters and the timer 1 latch to all ones and the CA1/CB1 stored
//   levels to one. No response is pending after reset.
// ----------------------------------------------------------------------------
module versatile_interface_adapter_unit (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	output logic       req_ready,
	input  logic [2:0] opcode,
	input  logic [3:0] reg_index,
	input  logic [7:0] write_data,
	input  logic       line_level,
	input  logic [7:0] port_a_pins,
	input  logic [7:0] port_b_pins,
	output logic       rsp_valid,
	input  logic       rsp_ready,
	output logic [7:0] read_data,
	output logic       irq,
	output logic       pb7_level
);

	// input stage
	logic       valid_s1;
	logic [2:0] op_s1;
	logic [3:0] idx_s1;
	logic [7:0] data_s1;
	logic       level_s1;
	logic [7:0] pa_s1;
	logic [7:0] pb_s1;

	// response stage
	logic       rsp_valid_s2;
	logic [7:0] read_data_s2;
	logic       irq_s2;
	logic       pb7_s2;

	// register file
	logic [7:0]  port_a_out_q, port_b_out_q, port_a_dir_q, port_b_dir_q;
	logic [15:0] t1_count_q, t1_latch_q, t2_count_q;
	logic [7:0]  t2_low_latch_q, shift_reg_q, aux_control_q, periph_control_q;
	logic [6:0]  flag_q, enable_q;
	logic        t1_fired_q, t2_fired_q, pb7_q, ca1_last_q, cb1_last_q;

	// next values
	logic [7:0]  port_a_out_d, port_b_out_d, port_a_dir_d, port_b_dir_d;
	logic [15:0] t1_count_d, t1_latch_d, t2_count_d;
	logic [7:0]  t2_low_latch_d, shift_reg_d, aux_control_d, periph_control_d;
	logic [6:0]  flag_d, enable_d;
	logic        t1_fired_d, t2_fired_d, pb7_d, ca1_last_d, cb1_last_d;
	logic [6:0]  flag_clr, flag_set;
	logic [7:0]  rd_data;
	logic [7:0]  pa_view, pb_view;
	logic        summary;
	logic        advance;

	// handshake: response register frees the input register
	assign advance   = valid_s1 && (!rsp_valid_s2 || rsp_ready);
	assign req_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_ready) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_ready && req_valid) begin
			op_s1    <= opcode;
			idx_s1   <= reg_index;
			data_s1  <= write_data;
			level_s1 <= line_level;
			pa_s1    <= port_a_pins;
			pb_s1    <= port_b_pins;
		end
	end

	// pin views: outputs where driven, pins elsewhere
	assign pa_view = (port_a_out_q & port_a_dir_q) | (pa_s1 & ~port_a_dir_q);
	assign pb_view = (port_b_out_q & port_b_dir_q) | (pb_s1 & ~port_b_dir_q);
	assign summary = |(flag_q & enable_q);

	// operation decode and register file next state
	always_comb begin
		port_a_out_d     = port_a_out_q;
		port_b_out_d     = port_b_out_q;
		port_a_dir_d     = port_a_dir_q;
		port_b_dir_d     = port_b_dir_q;
		t1_count_d       = t1_count_q;
		t1_latch_d       = t1_latch_q;
		t2_count_d       = t2_count_q;
		t2_low_latch_d   = t2_low_latch_q;
		shift_reg_d      = shift_reg_q;
		aux_control_d    = aux_control_q;
		periph_control_d = periph_control_q;
		enable_d         = enable_q;
		t1_fired_d       = t1_fired_q;
		t2_fired_d       = t2_fired_q;
		pb7_d            = pb7_q;
		ca1_last_d       = ca1_last_q;
		cb1_last_d       = cb1_last_q;
		flag_clr         = '0;
		flag_set         = '0;
		rd_data          = '0;

		case (vifa_pkg::op_t'(op_s1))
			vifa_pkg::OP_READ: begin
				case (vifa_pkg::reg_t'(idx_s1))
					vifa_pkg::REG_ORB: begin
						rd_data  = pb_view;
						flag_clr = vifa_pkg::FLG_CB1;
					end
					vifa_pkg::REG_ORA: begin
						rd_data  = pa_view;
						flag_clr = vifa_pkg::FLG_CA1 | vifa_pkg::FLG_CA2;
					end
					vifa_pkg::REG_DDRB: rd_data = port_b_dir_q;
					vifa_pkg::REG_DDRA: rd_data = port_a_dir_q;
					vifa_pkg::REG_T1CL: begin
						rd_data  = t1_count_q[7:0];
						flag_clr = vifa_pkg::FLG_T1;
					end
					vifa_pkg::REG_T1CH: rd_data = t1_count_q[15:8];
					vifa_pkg::REG_T1LL: rd_data = t1_latch_q[7:0];
					vifa_pkg::REG_T1LH: rd_data = t1_latch_q[15:8];
					vifa_pkg::REG_T2CL: begin
						rd_data  = t2_count_q[7:0];
						flag_clr = vifa_pkg::FLG_T2;
					end
					vifa_pkg::REG_T2CH: rd_data = t2_count_q[15:8];
					vifa_pkg::REG_SR: begin
						rd_data  = shift_reg_q;
						flag_clr = vifa_pkg::FLG_SR;
					end
					vifa_pkg::REG_ACR: rd_data = aux_control_q;
					vifa_pkg::REG_PCR: rd_data = periph_control_q;
					vifa_pkg::REG_IFR: rd_data = {summary, flag_q};
					vifa_pkg::REG_IER: rd_data = {1'b1, enable_q};
					default:           rd_data = pa_view;
				endcase
			end

			vifa_pkg::OP_WRITE: begin
				case (vifa_pkg::reg_t'(idx_s1))
					vifa_pkg::REG_ORB: begin
						port_b_out_d = data_s1;
						flag_clr     = vifa_pkg::FLG_CB1;
					end
					vifa_pkg::REG_ORA: begin
						port_a_out_d = data_s1;
						flag_clr     = vifa_pkg::FLG_CA1 | vifa_pkg::FLG_CA2;
					end
					vifa_pkg::REG_DDRB: port_b_dir_d = data_s1;
					vifa_pkg::REG_DDRA: port_a_dir_d = data_s1;
					vifa_pkg::REG_T1CL, vifa_pkg::REG_T1LL:
						t1_latch_d = {t1_latch_q[15:8], data_s1};
					vifa_pkg::REG_T1CH: begin
						// load counter from the full latch and rearm
						t1_latch_d = {data_s1, t1_latch_q[7:0]};
						t1_count_d = {data_s1, t1_latch_q[7:0]};
						t1_fired_d = 1'b0;
						if (aux_control_q[vifa_pkg::T1_PB7_EN_BIT]) begin
							pb7_d = 1'b0;
						end
						flag_clr = vifa_pkg::FLG_T1;
					end
					vifa_pkg::REG_T1LH: begin
						t1_latch_d = {data_s1, t1_latch_q[7:0]};
						flag_clr   = vifa_pkg::FLG_T1;
					end
					vifa_pkg::REG_T2CL: t2_low_latch_d = data_s1;
					vifa_pkg::REG_T2CH: begin
						t2_count_d = {data_s1, t2_low_latch_q};
						t2_fired_d = 1'b0;
						flag_clr   = vifa_pkg::FLG_T2;
					end
					vifa_pkg::REG_SR:  shift_reg_d      = data_s1;
					vifa_pkg::REG_ACR: aux_control_d    = data_s1;
					vifa_pkg::REG_PCR: periph_control_d = data_s1;
					vifa_pkg::REG_IFR: flag_clr         = data_s1[6:0];
					vifa_pkg::REG_IER: begin
						// bit 7 selects set or clear of the enables
						if (data_s1[7]) begin
							enable_d = enable_q | data_s1[6:0];
						end else begin
							enable_d = enable_q & ~data_s1[6:0];
						end
					end
					default: port_a_out_d = data_s1;
				endcase
			end

			vifa_pkg::OP_TICK: begin
				// timer 1: reload in free run, one flag per load in one-shot
				if (t1_count_q == '0) begin
					t1_count_d = vifa_pkg::TIMER_MAX;
					if (aux_control_q[vifa_pkg::T1_CONTINUOUS_BIT]) begin
						flag_set   = flag_set | vifa_pkg::FLG_T1;
						t1_count_d = t1_latch_q;
						pb7_d      = !pb7_q;
					end else if (!t1_fired_q) begin
						flag_set   = flag_set | vifa_pkg::FLG_T1;
						t1_fired_d = 1'b1;
						pb7_d      = 1'b1;
					end
				end else begin
					t1_count_d = t1_count_q - 16'd1;
				end
				// timer 2: counts only in timed mode
				if (!aux_control_q[vifa_pkg::T2_PULSE_MODE_BIT]) begin
					if (t2_count_q == '0) begin
						t2_count_d = vifa_pkg::TIMER_MAX;
						if (!t2_fired_q) begin
							flag_set   = flag_set | vifa_pkg::FLG_T2;
							t2_fired_d = 1'b1;
						end
					end else begin
						t2_count_d = t2_count_q - 16'd1;
					end
				end
			end

			vifa_pkg::OP_SET_CA1: begin
				if (periph_control_q[vifa_pkg::PCR_CA1_RISE] ? (!ca1_last_q && level_s1)
						: (ca1_last_q && !level_s1)) begin
					flag_set = vifa_pkg::FLG_CA1;
				end
				ca1_last_d = level_s1;
			end

			vifa_pkg::OP_SET_CB1: begin
				if (periph_control_q[vifa_pkg::PCR_CB1_RISE] ? (!cb1_last_q && level_s1)
						: (cb1_last_q && !level_s1)) begin
					flag_set = vifa_pkg::FLG_CB1;
				end
				cb1_last_d = level_s1;
			end

			default: ;
		endcase

		flag_d = (flag_q & ~flag_clr) | flag_set;
	end

	// register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			port_a_out_q     <= '0;
			port_b_out_q     <= '0;
			port_a_dir_q     <= '0;
			port_b_dir_q     <= '0;
			t1_count_q       <= vifa_pkg::TIMER_MAX;
			t1_latch_q       <= vifa_pkg::TIMER_MAX;
			t2_count_q       <= vifa_pkg::TIMER_MAX;
			t2_low_latch_q   <= '0;
			shift_reg_q      <= '0;
			aux_control_q    <= '0;
			periph_control_q <= '0;
			flag_q           <= '0;
			enable_q         <= '0;
			t1_fired_q       <= 1'b0;
			t2_fired_q       <= 1'b0;
			pb7_q            <= 1'b0;
			ca1_last_q       <= 1'b1;
			cb1_last_q       <= 1'b1;
		end else if (advance) begin
			port_a_out_q     <= port_a_out_d;
			port_b_out_q     <= port_b_out_d;
			port_a_dir_q     <= port_a_dir_d;
			port_b_dir_q     <= port_b_dir_d;
			t1_count_q       <= t1_count_d;
			t1_latch_q       <= t1_latch_d;
			t2_count_q       <= t2_count_d;
			t2_low_latch_q   <= t2_low_latch_d;
			shift_reg_q      <= shift_reg_d;
			aux_control_q    <= aux_control_d;
			periph_control_q <= periph_control_d;
			flag_q           <= flag_d;
			enable_q         <= enable_d;
			t1_fired_q       <= t1_fired_d;
			t2_fired_q       <= t2_fired_d;
			pb7_q            <= pb7_d;
			ca1_last_q       <= ca1_last_d;
			cb1_last_q       <= cb1_last_d;
		end
	end

	// response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_s2 <= 1'b0;
		end else if (!rsp_valid_s2 || rsp_ready) begin
			rsp_valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			read_data_s2 <= rd_data;
			irq_s2       <= |(flag_d & enable_d);
			pb7_s2       <= pb7_d;
		end
	end

	assign rsp_valid = rsp_valid_s2;
	assign read_data = read_data_s2;
	assign irq       = irq_s2;
	assign pb7_level = pb7_s2;

endmodule

// ===== tb/sv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for versatile_interface_adapter_unit. A directed table
// covers reset values, register extremes, flag clearing, edges and timer
// underflows. Random requests follow, most of them grouped into timer and
// handshake sequences. A shadow copy of the register file predicts each
// response that has no typed-in expectation, and responses are compared in order under random backpressure.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RANDOM_REQUESTS = 1800;
	localparam int IDLE_LIMIT      = 2000;
	localparam int LONG_HOLD       = 300;
	localparam int DRAIN_AT        = 1000;

	typedef struct packed {
		logic [7:0] rd;
		logic       irq;
		logic       pb7;
	} adapter_rsp_t;

	typedef struct packed {
		logic [2:0]   op;
		logic [3:0]   idx;
		logic [7:0]   data;
		logic         lvl;
		logic [7:0]   pa;
		logic [7:0]   pb;
		logic         chk;
		adapter_rsp_t want;
	} stim_row_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       req_valid = 1'b0;
	logic       req_ready;
	logic [2:0] opcode = '0;
	logic [3:0] reg_index = '0;
	logic [7:0] write_data = '0;
	logic       line_level = 1'b0;
	logic [7:0] port_a_pins = '0;
	logic [7:0] port_b_pins = '0;
	logic       rsp_valid;
	logic       rsp_ready = 1'b0;
	logic [7:0] read_data;
	logic       irq;
	logic       pb7_level;

	// typed-in expectation travelling with the request
	logic         fixed_chk = 1'b0;
	adapter_rsp_t fixed_rsp = '0;

	// shadow register file, reset values
	logic [7:0]  ora_q = '0, orb_q = '0, ddra_q = '0, ddrb_q = '0;
	logic [15:0] t1_count = vifa_pkg::TIMER_MAX, t1_latch = vifa_pkg::TIMER_MAX;
	logic [15:0] t2_count = vifa_pkg::TIMER_MAX;
	logic [7:0]  t2_latch_lo = '0, shift_q = '0, acr_q = '0, pcr_q = '0;
	logic [6:0]  flags_q = '0, enables_q = '0;
	logic        t1_spent = 1'b0, t2_spent = 1'b0, pb7_q = 1'b0;
	logic        ca1_q = 1'b1, cb1_q = 1'b1;

	adapter_rsp_t pending_rsp[$];
	stim_row_t    directed_rows[$];
	int           mismatches = 0;
	int           sent_count = 0;
	int           burst_left = 0;
	int           idle_cycles = 0;

	// long receiver hold-off, requested by toggling
	logic hold_tog = 1'b0, hold_seen = 1'b0;
	int   hold_left = 0;
	int   rx_mode = 0, rx_left = 0, rx_phase = 0;

	versatile_interface_adapter_unit dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_ready  (req_ready),
		.opcode     (opcode),
		.reg_index  (reg_index),
		.write_data (write_data),
		.line_level (line_level),
		.port_a_pins(port_a_pins),
		.port_b_pins(port_b_pins),
		.rsp_valid  (rsp_valid),
		.rsp_ready  (rsp_ready),
		.read_data  (read_data),
		.irq        (irq),
		.pb7_level  (pb7_level)
	);

	always #5 clk = ~clk;

	// apply one request to the shadow state and return the response it causes
	function automatic adapter_rsp_t predict_adapter(logic [2:0] op, logic [3:0] idx,
			logic [7:0] data, logic lvl, logic [7:0] pa, logic [7:0] pb);
		adapter_rsp_t r;
		logic [7:0]   pa_view;
		logic         hit;
		r.rd = '0;
		pa_view = (ora_q & ddra_q) | (pa & ~ddra_q);
		case (op)
			vifa_pkg::OP_READ: begin
				case (idx)
					vifa_pkg::REG_ORB: begin
						flags_q &= ~vifa_pkg::FLG_CB1;
						r.rd = (orb_q & ddrb_q) | (pb & ~ddrb_q);
					end
					vifa_pkg::REG_ORA: begin
						flags_q &= ~(vifa_pkg::FLG_CA1 | vifa_pkg::FLG_CA2);
						r.rd = pa_view;
					end
					vifa_pkg::REG_DDRB: r.rd = ddrb_q;
					vifa_pkg::REG_DDRA: r.rd = ddra_q;
					vifa_pkg::REG_T1CL: begin
						flags_q &= ~vifa_pkg::FLG_T1;
						r.rd = t1_count[7:0];
					end
					vifa_pkg::REG_T1CH: r.rd = t1_count[15:8];
					vifa_pkg::REG_T1LL: r.rd = t1_latch[7:0];
					vifa_pkg::REG_T1LH: r.rd = t1_latch[15:8];
					vifa_pkg::REG_T2CL: begin
						flags_q &= ~vifa_pkg::FLG_T2;
						r.rd = t2_count[7:0];
					end
					vifa_pkg::REG_T2CH: r.rd = t2_count[15:8];
					vifa_pkg::REG_SR: begin
						flags_q &= ~vifa_pkg::FLG_SR;
						r.rd = shift_q;
					end
					vifa_pkg::REG_ACR: r.rd = acr_q;
					vifa_pkg::REG_PCR: r.rd = pcr_q;
					vifa_pkg::REG_IFR: r.rd = {|(flags_q & enables_q), flags_q};
					vifa_pkg::REG_IER: r.rd = {1'b1, enables_q};
					default: r.rd = pa_view;
				endcase
			end
			vifa_pkg::OP_WRITE: begin
				case (idx)
					vifa_pkg::REG_ORB: begin
						orb_q = data;
						flags_q &= ~vifa_pkg::FLG_CB1;
					end
					vifa_pkg::REG_ORA: begin
						ora_q = data;
						flags_q &= ~(vifa_pkg::FLG_CA1 | vifa_pkg::FLG_CA2);
					end
					vifa_pkg::REG_DDRB: ddrb_q = data;
					vifa_pkg::REG_DDRA: ddra_q = data;
					vifa_pkg::REG_T1CL, vifa_pkg::REG_T1LL: t1_latch[7:0] = data;
					vifa_pkg::REG_T1CH: begin
						t1_latch[15:8] = data;
						t1_count = t1_latch;
						t1_spent = 1'b0;
						if (acr_q[vifa_pkg::T1_PB7_EN_BIT])
							pb7_q = 1'b0;
						flags_q &= ~vifa_pkg::FLG_T1;
					end
					vifa_pkg::REG_T1LH: begin
						t1_latch[15:8] = data;
						flags_q &= ~vifa_pkg::FLG_T1;
					end
					vifa_pkg::REG_T2CL: t2_latch_lo = data;
					vifa_pkg::REG_T2CH: begin
						t2_count = {data, t2_latch_lo};
						t2_spent = 1'b0;
						flags_q &= ~vifa_pkg::FLG_T2;
					end
					vifa_pkg::REG_SR:  shift_q = data;
					vifa_pkg::REG_ACR: acr_q = data;
					vifa_pkg::REG_PCR: pcr_q = data;
					vifa_pkg::REG_IFR: flags_q &= ~data[6:0];
					vifa_pkg::REG_IER: begin
						if (data[7])
							enables_q |= data[6:0];
						else
							enables_q &= ~data[6:0];
					end
					default: ora_q = data;
				endcase
			end
			vifa_pkg::OP_TICK: begin
				// timer 1: free-run reloads and toggles PB7, one-shot fires once
				if (t1_count == '0) begin
					t1_count = vifa_pkg::TIMER_MAX;
					if (acr_q[vifa_pkg::T1_CONTINUOUS_BIT]) begin
						flags_q |= vifa_pkg::FLG_T1;
						t1_count = t1_latch;
						pb7_q = ~pb7_q;
					end else if (!t1_spent) begin
						flags_q |= vifa_pkg::FLG_T1;
						t1_spent = 1'b1;
						pb7_q = 1'b1;
					end
				end else begin
					t1_count = t1_count - 16'd1;
				end
				// timer 2 counts only in timed mode
				if (!acr_q[vifa_pkg::T2_PULSE_MODE_BIT]) begin
					if (t2_count == '0) begin
						t2_count = vifa_pkg::TIMER_MAX;
						if (!t2_spent) begin
							flags_q |= vifa_pkg::FLG_T2;
							t2_spent = 1'b1;
						end
					end else begin
						t2_count = t2_count - 16'd1;
					end
				end
			end
			vifa_pkg::OP_SET_CA1: begin
				hit = pcr_q[vifa_pkg::PCR_CA1_RISE] ? (!ca1_q && lvl) : (ca1_q && !lvl);
				if (hit)
					flags_q |= vifa_pkg::FLG_CA1;
				ca1_q = lvl;
			end
			vifa_pkg::OP_SET_CB1: begin
				hit = pcr_q[vifa_pkg::PCR_CB1_RISE] ? (!cb1_q && lvl) : (cb1_q && !lvl);
				if (hit)
					flags_q |= vifa_pkg::FLG_CB1;
				cb1_q = lvl;
			end
			default: ;
		endcase
		r.irq = |(flags_q & enables_q);
		r.pb7 = pb7_q;
		return r;
	endfunction

	task automatic add_row(input logic [2:0] op, input logic [3:0] idx, input logic [7:0] data,
			input logic lvl, input logic [7:0] pa, input logic [7:0] pb, input logic chk,
			input logic [7:0] rd, input logic irq_bit, input logic pb7_bit);
		stim_row_t row;
		row.op = op;
		row.idx = idx;
		row.data = data;
		row.lvl = lvl;
		row.pa = pa;
		row.pb = pb;
		row.chk = chk;
		row.want = {rd, irq_bit, pb7_bit};
		directed_rows.push_back(row);
	endtask

	function automatic stim_row_t make_row(logic [2:0] op, logic [3:0] idx, logic [7:0] data);
		stim_row_t row;
		row.op = op;
		row.idx = idx;
		row.data = data;
		row.lvl = 1'($urandom_range(0, 1));
		row.pa = 8'($urandom_range(0, 255));
		row.pb = 8'($urandom_range(0, 255));
		row.chk = 1'b0;
		row.want = '0;
		return row;
	endfunction

	// offer one request; the sender works in bursts with random gaps
	task automatic issue_request(input stim_row_t row);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			if ($urandom_range(0, 3) != 0) begin
				req_valid <= 1'b0;
				repeat ($urandom_range(1, 8)) @(posedge clk);
			end
		end
		burst_left--;
		req_valid <= 1'b1;
		opcode <= row.op;
		reg_index <= row.idx;
		write_data <= row.data;
		line_level <= row.lvl;
		port_a_pins <= row.pa;
		port_b_pins <= row.pb;
		fixed_chk <= row.chk;
		fixed_rsp <= row.want;
		do @(posedge clk); while (!req_ready);
		sent_count++;
	endtask

	// response check first, then prediction of the request accepted at this edge
	always @(posedge clk) begin : scoreboard
		adapter_rsp_t got;
		adapter_rsp_t want;
		adapter_rsp_t predicted;
		if (arst_n) begin
			if (rsp_valid && rsp_ready) begin
				got = {read_data, irq, pb7_level};
				if (pending_rsp.size() == 0) begin
					$display("%0t: unexpected response rd=%02h irq=%0b pb7=%0b",
						$time, got.rd, got.irq, got.pb7);
					mismatches++;
				end else begin
					want = pending_rsp.pop_front();
					if (got !== want) begin
						$display("%0t: response mismatch: expected rd=%02h irq=%0b pb7=%0b, got rd=%02h irq=%0b pb7=%0b",
							$time, want.rd, want.irq, want.pb7, got.rd, got.irq, got.pb7);
						mismatches++;
					end
				end
			end
			if (req_valid && req_ready) begin
				predicted = predict_adapter(opcode, reg_index, write_data, line_level,
					port_a_pins, port_b_pins);
				pending_rsp.push_back(fixed_chk ? fixed_rsp : predicted);
			end
		end
	end

	// receiver: switches among random ready modes, plus a long hold on request
	always @(posedge clk) begin
		if (arst_n) begin
			if (hold_seen != hold_tog) begin
				hold_seen <= hold_tog;
				hold_left <= LONG_HOLD;
				rsp_ready <= 1'b0;
			end else if (hold_left != 0) begin
				hold_left <= hold_left - 1;
				rsp_ready <= 1'b0;
			end else begin
				if (rx_left == 0) begin
					rx_mode <= $urandom_range(0, 2);
					rx_left <= $urandom_range(10, 80);
				end else begin
					rx_left <= rx_left - 1;
				end
				rx_phase <= rx_phase + 1;
				case (rx_mode)
					0:       rsp_ready <= 1'b1;
					1:       rsp_ready <= 1'($urandom_range(0, 1));
					default: rsp_ready <= (rx_phase % 5) < 2;
				endcase
			end
		end
	end

	// watchdog on cycles without any handshake
	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("%0t: no handshake for %0d cycles", $time, IDLE_LIMIT);
				$display("tb NOT OK");
				$finish;
			end
		end
	end

	// stimulus
	initial begin : stimulus
		logic [2:0] op;
		logic [3:0] idx;
		logic [7:0] data;
		int         kind;
		int         pick;
		int         next_hold_at;
		bit         drained;
		next_hold_at = 600;
		drained = 1'b0;

		// directed table: reset values, extremes, flag handling, edges, timers
		add_row(vifa_pkg::OP_READ, vifa_pkg::REG_IFR,
			8'h00, 1'b0, 8'h00, 8'h00, 1'b1, 8'h00, 1'b0, 1'b0);
		add_row(vifa_pkg::OP_READ, vifa_pkg::REG_IER,
			8'h00, 1'b0, 8'h00, 8'h00, 1'b1, 8'h80, 1'b0, 1'b0);
		add_row(vifa_pkg::OP_READ, vifa_pkg::REG_T1CL,
			8'h00, 1'b0, 8'hFF, 8'hFF, 1'b1, 8'hFF, 1'b0, 1'b0);
		add_row(vifa_pkg::OP_READ, vifa_pkg::REG_T2CH,
			8'h00, 1'b0, 8'h00, 8'h00, 1'b1, 8'hFF, 1'b0, 1'b0);
		add_row(vifa_pkg::OP_READ, vifa_pkg::REG_ORA,
			8'h00, 1'b0, 8'hA5, 8'h00, 1'b1, 8'hA5, 1'b0, 1'b0);
		add_row(vifa_pkg::OP_READ, vifa_pkg::REG_ORB,
			8'h00, 1'b0, 8'h00, 8'h5A, 1'b1, 8'h5A, 1'b0, 1'b0);
		add_row(vifa_pkg::OP_WRITE, vifa_pkg::REG_DDRA,
			8'hFF, 1'b0, 8'h00, 8'h00, 1'b1, 8'h00, 1'b0, 1'b0);
		add_row(vifa_pkg::OP_WRITE, vifa_pkg::REG_ORA_NH,
			8'h3C, 1'b1, 8'hFF, 8'hFF, 1'b1, 8'h00, 1'b0, 1'b0);
		add_row(vifa_pkg::OP_READ, vifa_pkg::REG_ORA_NH,
			8'h00, 1'b0, 8'h00, 8'h00, 1'b1, 8'h3C, 1'b0, 1'b0);
		add_row(vifa_pkg::OP_WRITE, vifa_pkg::REG_IER,
			8'hFF, 1'b0, 8'h00, 8'h00, 1'b1, 8'h00, 1'b0, 1'b0);
		// falling CA1 edge with default polarity raises the flag
		add_row(vifa_pkg::OP_SET_CA1, vifa_pkg::REG_ORB,
			8'h00, 1'b0, 8'h00, 8'h00, 1'b1, 8'h00, 1'b1, 1'b0);
		add_row(vifa_pkg::OP_READ, vifa_pkg::REG_IFR,
			8'h00, 1'b0, 8'h00, 8'h00, 1'b1, 8'h82, 1'b1, 1'b0);
		add_row(vifa_pkg::OP_WRITE, vifa_pkg::REG_IFR,
			8'h7F, 1'b0, 8'h00, 8'h00, 1'b1, 8'h00, 1'b0, 1'b0);
		// same level again: no edge
		add_row(vifa_pkg::OP_SET_CB1, vifa_pkg::REG_ORB,
			8'h00, 1'b1, 8'h00, 8'h00, 1'b1, 8'h00, 1'b0, 1'b0);
		add_row(vifa_pkg::OP_WRITE, vifa_pkg::REG_PCR,
			8'h11, 1'b0, 8'h00, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0);
		add_row(vifa_pkg::OP_SET_CB1, vifa_pkg::REG_ORB,
			8'h00, 1'b0, 8'h00, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0);
		add_row(vifa_pkg::OP_SET_CB1, vifa_pkg::REG_ORB,
			8'h00, 1'b1, 8'h00, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0);
		// timer 1 free-run with PB7, short period
		add_row(vifa_pkg::OP_WRITE, vifa_pkg::REG_ACR,
			8'hC0, 1'b0, 8'h00, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0);
		add_row(vifa_pkg::OP_WRITE, vifa_pkg::REG_T1CL,
			8'h01, 1'b0, 8'h00, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0);
		add_row(vifa_pkg::OP_WRITE, vifa_pkg::REG_T1CH,
			8'h00, 1'b0, 8'h00, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0);
		add_row(vifa_pkg::OP_TICK, vifa_pkg::REG_ORB,
			8'h00, 1'b0, 8'h00, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0);
		add_row(vifa_pkg::OP_TICK, vifa_pkg::REG_ORB,
			8'h00, 1'b0, 8'h00, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0);
		// timer 2 loaded with zero underflows on the next tick
		add_row(vifa_pkg::OP_WRITE, vifa_pkg::REG_T2CH,
			8'h00, 1'b0, 8'h00, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0);
		add_row(vifa_pkg::OP_TICK, vifa_pkg::REG_ORB,
			8'h00, 1'b0, 8'h00, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0);
		// unused opcodes change nothing
		add_row(vifa_pkg::OP_SET_CB1 + 3'd3, vifa_pkg::REG_IER,
			8'hFF, 1'b1, 8'hFF, 8'hFF, 1'b0, 8'h00, 1'b0, 1'b0);
		add_row(vifa_pkg::OP_SET_CB1 + 3'd1, vifa_pkg::REG_ORA,
			8'h00, 1'b0, 8'h00, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0);

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			issue_request(directed_rows[i]);

		// random part: timer sequences, handshake sequences and single requests
		while (sent_count < directed_rows.size() + RANDOM_REQUESTS) begin
			if (sent_count >= next_hold_at) begin
				hold_tog <= ~hold_tog;
				next_hold_at += 800;
			end
			if (!drained && sent_count >= DRAIN_AT) begin
				// sender pauses until every response is back
				req_valid <= 1'b0;
				do @(posedge clk); while (pending_rsp.size() != 0);
				drained = 1'b1;
			end
			kind = $urandom_range(0, 9);
			if (kind == 0) begin
				issue_request(make_row(vifa_pkg::OP_WRITE, vifa_pkg::REG_ACR,
					8'($urandom_range(0, 255))));
				issue_request(make_row(vifa_pkg::OP_WRITE, vifa_pkg::REG_T1LL,
					8'($urandom_range(0, 12))));
				issue_request(make_row(vifa_pkg::OP_WRITE, vifa_pkg::REG_T1CH, 8'h00));
				issue_request(make_row(vifa_pkg::OP_WRITE, vifa_pkg::REG_T2CL,
					8'($urandom_range(0, 12))));
				issue_request(make_row(vifa_pkg::OP_WRITE, vifa_pkg::REG_T2CH, 8'h00));
				repeat ($urandom_range(2, 24))
					issue_request(make_row(vifa_pkg::OP_TICK, 4'($urandom_range(0, 15)),
						8'($urandom_range(0, 255))));
				issue_request(make_row(vifa_pkg::OP_READ, vifa_pkg::REG_IFR,
					8'($urandom_range(0, 255))));
			end else if (kind == 1) begin
				issue_request(make_row(vifa_pkg::OP_WRITE, vifa_pkg::REG_PCR,
					8'($urandom_range(0, 255))));
				repeat ($urandom_range(4, 10)) begin
					op = $urandom_range(0, 1) ? vifa_pkg::OP_SET_CA1 : vifa_pkg::OP_SET_CB1;
					issue_request(make_row(op, 4'($urandom_range(0, 15)),
						8'($urandom_range(0, 255))));
				end
				issue_request(make_row(vifa_pkg::OP_READ, vifa_pkg::REG_IFR,
					8'($urandom_range(0, 255))));
				idx = $urandom_range(0, 1) ? vifa_pkg::REG_ORA : vifa_pkg::REG_ORB;
				issue_request(make_row(vifa_pkg::OP_READ, idx, 8'($urandom_range(0, 255))));
			end else begin
				pick = $urandom_range(0, 99);
				if (pick < 28)
					op = vifa_pkg::OP_READ;
				else if (pick < 60)
					op = vifa_pkg::OP_WRITE;
				else if (pick < 85)
					op = vifa_pkg::OP_TICK;
				else if (pick < 92)
					op = vifa_pkg::OP_SET_CA1;
				else if (pick < 98)
					op = vifa_pkg::OP_SET_CB1;
				else
					op = 3'(vifa_pkg::OP_SET_CB1 + $urandom_range(1, 3));
				idx = 4'($urandom_range(0, 15));
				data = 8'($urandom_range(0, 255));
				// keep timer loads short most of the time so underflows happen
				if ((idx == vifa_pkg::REG_T1CH || idx == vifa_pkg::REG_T1LH
						|| idx == vifa_pkg::REG_T2CH) && $urandom_range(0, 3) != 0)
					data = 8'h00;
				if ((idx == vifa_pkg::REG_T1CL || idx == vifa_pkg::REG_T1LL
						|| idx == vifa_pkg::REG_T2CL) && $urandom_range(0, 3) != 0)
					data = 8'($urandom_range(0, 12));
				issue_request(make_row(op, idx, data));
			end
		end

		req_valid <= 1'b0;
		do @(posedge clk); while (pending_rsp.size() != 0);
		repeat (8) @(posedge clk);
		if (mismatches == 0 && pending_rsp.size() == 0)
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end

endmodule
